/* src/mcd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared widths, codes and item types for the min/max column decimator.
// ----------------------------------------------------------------------------
package mcd_pkg;

    localparam int TIME_BITS   = 32;
    localparam int VALUE_BITS  = 32;
    localparam int COUNT_BITS  = 13;
    localparam int INDEX_BITS  = 12;
    localparam int ACTION_BITS = 2;
    localparam int MAX_COLUMNS = 4096;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [ACTION_BITS-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_SAMPLE = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_READ   = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_START = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_END   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = 2'd2;

    localparam logic [COUNT_BITS-1:0] COLUMN_COUNT_RESET = 13'd1024;

    typedef struct packed {
        logic [ACTION_BITS-1:0]       action;
        logic [TIME_BITS-1:0]         sample_time;
        logic signed [VALUE_BITS-1:0] sample_value;
        logic                         value_valid;
        logic [INDEX_BITS-1:0]        column_index;
    } cmd_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] column_min;
        logic signed [VALUE_BITS-1:0] column_max;
        logic                         column_empty;
    } rsp_t;

endpackage
`default_nettype wire

/* src/mcd_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mcd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* src/min_max_column_decimator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// min_max_column_decimator
// Min/max waveform decimation into display columns, kept in one RAM.
// ----------------------------------------------------------------------------
// One item is handled at a time. For a sample item the column number comes
// from a shift-and-add divider that, for each column-count bit from the top,
// doubles the remainder and then adds the time offset when the bit is set;
// then the column entry is read and written back through the RAM. A sample
// that is skipped leaves from idle or from the window check, a read item
// waits while the previous result is still held, and a clear item sweeps
// the RAM one entry a cycle. After reset the same sweep runs before the
// first item is taken; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module min_max_column_decimator #(
    parameter int MAX_COLUMNS = mcd_pkg::MAX_COLUMNS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cmd_valid,
    output logic                                     cmd_stall,
    input  wire mcd_pkg::cmd_t                       cmd_item,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_stall,
    output mcd_pkg::rsp_t                            rsp_item,
    input  wire logic                                cfg_we,
    input  wire logic [mcd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [mcd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int TB = mcd_pkg::TIME_BITS;
    localparam int VB = mcd_pkg::VALUE_BITS;
    localparam int NB = $clog2(MAX_COLUMNS + 1);
    localparam int CB = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int EW = (NB > mcd_pkg::COUNT_BITS) ? NB : mcd_pkg::COUNT_BITS;
    localparam int BW = (NB > 1) ? $clog2(NB) : 1;
    localparam int IW = (mcd_pkg::INDEX_BITS > NB) ? mcd_pkg::INDEX_BITS + 1 : NB + 1;
    localparam int ENTRY_W = 2 * VB + 1;

    localparam logic [CB-1:0] LAST_COLUMN = CB'(MAX_COLUMNS - 1);
    localparam logic [BW-1:0] TOP_BIT     = BW'(NB - 1);

    typedef struct packed {
        logic                 filled;
        logic signed [VB-1:0] max_val;
        logic signed [VB-1:0] min_val;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_LOOKUP,
        ST_UPDATE,
        ST_RD_WAIT
    } state_t;

    // config
    logic [TB-1:0]                  start_reg;
    logic [TB-1:0]                  end_reg;
    logic [mcd_pkg::COUNT_BITS-1:0] count_reg;

    // control
    state_t          state_reg, state_next;
    logic [CB-1:0]   clr_cnt_reg, clr_cnt_next;
    logic            rsp_valid_reg, rsp_valid_next;
    mcd_pkg::rsp_t   rsp_item_reg, rsp_item_next;

    // datapath
    logic [TB-1:0]        d_reg, d_next;
    logic [TB-1:0]        w_reg, w_next;
    logic [TB-1:0]        r_reg, r_next;
    logic [NB-1:0]        q_reg, q_next;
    logic [BW-1:0]        bit_reg, bit_next;
    logic                 phase_reg, phase_next;
    logic                 win_ok_reg, win_ok_next;
    logic                 rd_hit_reg, rd_hit_next;
    logic signed [VB-1:0] v_reg, v_next;

    logic            cmd_accept;
    logic [NB-1:0]   n_eff;
    logic [EW-1:0]   count_wide;
    logic            idx_in_range;
    logic [TB:0]     r_dbl;
    logic [TB:0]     r_dbl_sub;
    logic [TB:0]     r_add;
    logic [TB:0]     r_add_sub;
    logic            dbl_ge;
    logic            add_ge;
    logic [NB-1:0]   q_inc;

    logic            ram_wr_en;
    logic [CB-1:0]   ram_wr_addr;
    entry_t          ram_wr_data;
    logic            ram_rd_en;
    logic [CB-1:0]   ram_rd_addr;
    entry_t          ram_rd_data;

    assign cmd_stall  = (state_reg != ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_item   = rsp_item_reg;

    assign count_wide   = EW'(count_reg);
    assign n_eff        = (count_wide > EW'(MAX_COLUMNS)) ? NB'(MAX_COLUMNS) : NB'(count_wide);
    assign idx_in_range = (IW'(cmd_item.column_index) < IW'(MAX_COLUMNS));

    // divider step: double the remainder, then add d when the count bit is set
    assign r_dbl     = {r_reg, 1'b0};
    assign dbl_ge    = (r_dbl >= {1'b0, w_reg});
    assign r_dbl_sub = r_dbl - {1'b0, w_reg};
    assign r_add     = {1'b0, r_reg} + {1'b0, d_reg};
    assign add_ge    = (r_add >= {1'b0, w_reg});
    assign r_add_sub = r_add - {1'b0, w_reg};
    assign q_inc     = q_reg + NB'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= '0;
            count_reg <= mcd_pkg::COLUMN_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mcd_pkg::REG_WINDOW_START: start_reg <= cfg_data[TB-1:0];
                mcd_pkg::REG_WINDOW_END:   end_reg   <= cfg_data[TB-1:0];
                mcd_pkg::REG_COLUMN_COUNT: count_reg <= cfg_data[mcd_pkg::COUNT_BITS-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_item_next  = rsp_item_reg;
        d_next         = d_reg;
        w_next         = w_reg;
        r_next         = r_reg;
        q_next         = q_reg;
        bit_next       = bit_reg;
        phase_next     = phase_reg;
        win_ok_next    = win_ok_reg;
        rd_hit_next    = rd_hit_reg;
        v_next         = v_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = clr_cnt_reg;
        ram_wr_data    = '0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = CB'(cmd_item.column_index);

        case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en    = 1'b1;
                clr_cnt_next = clr_cnt_reg + CB'(1);
                if (clr_cnt_reg == LAST_COLUMN)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    case (cmd_item.action)
                        mcd_pkg::ACT_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        mcd_pkg::ACT_SAMPLE:
                        begin
                            d_next      = cmd_item.sample_time - start_reg;
                            w_next      = end_reg - start_reg;
                            win_ok_next = (end_reg > start_reg) &&
                                          (cmd_item.sample_time >= start_reg);
                            v_next      = cmd_item.sample_value;
                            if (cmd_item.value_valid)
                            begin
                                state_next = ST_CHECK;
                            end
                        end
                        mcd_pkg::ACT_READ:
                        begin
                            ram_rd_en   = idx_in_range;
                            rd_hit_next = idx_in_range;
                            state_next  = ST_RD_WAIT;
                        end
                        default: ;
                    endcase
                end
            end

            ST_CHECK:
            begin
                r_next     = '0;
                q_next     = '0;
                bit_next   = TOP_BIT;
                phase_next = 1'b0;
                if (win_ok_reg && (d_reg < w_reg) && (n_eff != '0))
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_DIV:
            begin
                phase_next = !phase_reg;
                if (!phase_reg)
                begin
                    q_next = q_reg << 1;
                    if (dbl_ge)
                    begin
                        r_next    = r_dbl_sub[TB-1:0];
                        q_next[0] = 1'b1;
                    end
                    else
                    begin
                        r_next = r_dbl[TB-1:0];
                    end
                end
                else
                begin
                    if (n_eff[bit_reg])
                    begin
                        if (add_ge)
                        begin
                            r_next = r_add_sub[TB-1:0];
                            q_next = q_inc;
                        end
                        else
                        begin
                            r_next = r_add[TB-1:0];
                        end
                    end
                    bit_next = bit_reg - BW'(1);
                    if (bit_reg == '0)
                    begin
                        state_next = ST_LOOKUP;
                    end
                end
            end

            ST_LOOKUP:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = CB'(q_reg);
                state_next  = ST_UPDATE;
            end

            ST_UPDATE:
            begin
                ram_wr_en          = 1'b1;
                ram_wr_addr        = CB'(q_reg);
                ram_wr_data.filled = 1'b1;
                if (!ram_rd_data.filled)
                begin
                    ram_wr_data.min_val = v_reg;
                    ram_wr_data.max_val = v_reg;
                end
                else
                begin
                    ram_wr_data.min_val = (v_reg < ram_rd_data.min_val) ?
                                          v_reg : ram_rd_data.min_val;
                    ram_wr_data.max_val = (v_reg > ram_rd_data.max_val) ?
                                          v_reg : ram_rd_data.max_val;
                end
                state_next = ST_IDLE;
            end

            ST_RD_WAIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    if (rd_hit_reg && ram_rd_data.filled)
                    begin
                        rsp_item_next.column_min   = ram_rd_data.min_val;
                        rsp_item_next.column_max   = ram_rd_data.max_val;
                        rsp_item_next.column_empty = 1'b0;
                    end
                    else
                    begin
                        rsp_item_next.column_min   = '0;
                        rsp_item_next.column_max   = '0;
                        rsp_item_next.column_empty = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_item_reg  <= rsp_item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg      <= d_next;
        w_reg      <= w_next;
        r_reg      <= r_next;
        q_reg      <= q_next;
        bit_reg    <= bit_next;
        phase_reg  <= phase_next;
        win_ok_reg <= win_ok_next;
        rd_hit_reg <= rd_hit_next;
        v_reg      <= v_next;
    end

    mcd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_COLUMNS),
        .ADDR_W(CB)
    ) u_column_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

`ifndef SYNTHESIS
    a_rsp_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_RD_WAIT))
        else $error("result appeared without a read");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_item_reg.column_empty) |->
        (rsp_item_reg.column_min == '0 && rsp_item_reg.column_max == '0))
        else $error("empty column result carries nonzero min/max");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (r_reg < w_reg))
        else $error("divider remainder out of range");

    a_ram_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
        else $error("same-entry read and write in one cycle");
`endif

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the min/max column decimator.
// ----------------------------------------------------------------------------
// A queue of command items feeds a bursty driver. Every accepted item is
// folded into a local copy of the column tallies, so each read item queues
// the column report it must produce. A monitor behind a randomly stalling
// receiver compares every report field by field. The run starts with
// directed cases: window edges, value extremes, skipped samples, unused
// action, clear, count saturation, zero count, empty window and reads above
// the count. It then goes through a series of window settings, three fixed
// and the rest random, each fed with samples that cluster on a few columns
// plus reads, clears and noise items.
// ----------------------------------------------------------------------------
module tb_top;

    import mcd_pkg::*;

    localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cmd_valid = 1'b0;
    logic                      cmd_stall;
    cmd_t                      cmd_item = '0;
    logic                      rsp_valid;
    logic                      rsp_stall = 1'b0;
    rsp_t                      rsp_item;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    // local copy of the configuration and column tallies
    logic [TIME_BITS-1:0]         win_start = '0;
    logic [TIME_BITS-1:0]         win_end = '0;
    logic [COUNT_BITS-1:0]        col_count = COLUMN_COUNT_RESET;
    logic signed [VALUE_BITS-1:0] tally_min [MAX_COLUMNS];
    logic signed [VALUE_BITS-1:0] tally_max [MAX_COLUMNS];
    bit                           tally_filled [MAX_COLUMNS];

    cmd_t pending_cmds [$];
    rsp_t column_reports [$];
    int   hot_cols [$];
    int   error_count = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   stall_span = 0;
    int   stall_level = 0;
    rsp_t want;

    min_max_column_decimator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        error_count++;
    endtask

    // column a sample at time t lands in, -1 when it is dropped
    function automatic int column_for(input logic [TIME_BITS-1:0] t);
        logic [63:0] ncols;
        logic [63:0] offs;
        logic [63:0] span;
        ncols = (col_count > MAX_COLUMNS) ? 64'(MAX_COLUMNS) : 64'(col_count);
        if (ncols == 0 || win_end <= win_start || t < win_start)
            return -1;
        offs = 64'(t) - 64'(win_start);
        span = 64'(win_end) - 64'(win_start);
        if (offs >= span)
            return -1;
        return int'((offs * ncols) / span);
    endfunction

    function automatic void decimate_item(input cmd_t c);
        int   col;
        rsp_t r;
        case (c.action)
            ACT_CLEAR:
            begin
                for (int i = 0; i < MAX_COLUMNS; i++)
                    tally_filled[i] = 1'b0;
            end
            ACT_SAMPLE:
            begin
                col = c.value_valid ? column_for(c.sample_time) : -1;
                if (col >= 0)
                begin
                    if (!tally_filled[col])
                    begin
                        tally_filled[col] = 1'b1;
                        tally_min[col] = $signed(c.sample_value);
                        tally_max[col] = $signed(c.sample_value);
                    end
                    else
                    begin
                        if ($signed(c.sample_value) < tally_min[col])
                            tally_min[col] = $signed(c.sample_value);
                        if ($signed(c.sample_value) > tally_max[col])
                            tally_max[col] = $signed(c.sample_value);
                    end
                end
            end
            ACT_READ:
            begin
                if (tally_filled[c.column_index])
                begin
                    r.column_min   = tally_min[c.column_index];
                    r.column_max   = tally_max[c.column_index];
                    r.column_empty = 1'b0;
                end
                else
                begin
                    r = '0;
                    r.column_empty = 1'b1;
                end
                column_reports.push_back(r);
            end
            default:
            begin
            end
        endcase
    endfunction

    // item of the given action with every other field random
    function automatic cmd_t noise_item(input logic [ACTION_BITS-1:0] act);
        cmd_t        c;
        logic [31:0] bits;
        bits = $urandom();
        c.action       = act;
        c.sample_time  = $urandom();
        c.sample_value = $urandom();
        c.value_valid  = bits[31];
        c.column_index = bits[INDEX_BITS-1:0];
        return c;
    endfunction

    task automatic push_sample(input logic [TIME_BITS-1:0] t, input logic [VALUE_BITS-1:0] v,
                               input logic ok);
        cmd_t c;
        int   col;
        c = noise_item(ACT_SAMPLE);
        c.sample_time  = t;
        c.sample_value = v;
        c.value_valid  = ok;
        pending_cmds.push_back(c);
        col = column_for(t);
        if (ok && col >= 0)
        begin
            hot_cols.push_back(col);
            if (hot_cols.size() > 16)
                void'(hot_cols.pop_front());
        end
    endtask

    task automatic push_read(input int idx);
        cmd_t c;
        c = noise_item(ACT_READ);
        c.column_index = idx[INDEX_BITS-1:0];
        pending_cmds.push_back(c);
    endtask

    // wait until every item is sent and every report is back
    task automatic drain(input int settle);
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_valid || column_reports.size() != 0);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_WINDOW_START: win_start = data;
            REG_WINDOW_END:   win_end = data;
            REG_COLUMN_COUNT: col_count = data[COUNT_BITS-1:0];
            default:
            begin
            end
        endcase
    endtask

    // a trailing read marks the end of the previous phase, then reprogram
    task automatic set_window(input logic [31:0] s, input logic [31:0] e,
                              input logic [31:0] cdata);
        push_read($urandom_range(0, MAX_COLUMNS - 1));
        drain(64);
        write_reg(REG_WINDOW_START, s);
        write_reg(REG_WINDOW_END, e);
        write_reg(REG_COLUMN_COUNT, cdata);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        hot_cols.delete();
    endtask

    // driver: bursts of items with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
                decimate_item(cmd_item);
            if (!cmd_valid || !cmd_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    cmd_valid <= 1'b0;
                end
                else if (pending_cmds.size() == 0)
                begin
                    cmd_valid <= 1'b0;
                end
                else
                begin
                    cmd_valid <= 1'b1;
                    cmd_item  <= pending_cmds.pop_front();
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // monitor: checks reports, stalls with a density that changes now and then
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (column_reports.size() == 0)
                begin
                    flag_error("column report with no read pending");
                end
                else
                begin
                    want = column_reports.pop_front();
                    if (rsp_item.column_min !== want.column_min)
                        flag_error($sformatf("column_min %0d, expected %0d",
                                             rsp_item.column_min, want.column_min));
                    if (rsp_item.column_max !== want.column_max)
                        flag_error($sformatf("column_max %0d, expected %0d",
                                             rsp_item.column_max, want.column_max));
                    if (rsp_item.column_empty !== want.column_empty)
                        flag_error($sformatf("column_empty %0b, expected %0b",
                                             rsp_item.column_empty, want.column_empty));
                end
            end
            if (stall_span == 0)
            begin
                stall_span = $urandom_range(16, 128);
                stall_level = $urandom_range(0, 3);
            end
            else
            begin
                stall_span--;
            end
            rsp_stall <= ($urandom_range(0, 3) < stall_level);
        end
    end

    initial
    begin
        #1_500_000;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        logic [31:0] s;
        logic [31:0] e;
        logic [31:0] cdata;
        logic [31:0] bits;
        logic [31:0] span;
        logic [31:0] t;
        logic [31:0] v;
        logic [63:0] span64;
        logic [31:0] hot_times [6];
        int          n;
        int          n_eff;
        int          pick;
        int          clears_left;
        bit          window_ok;
        cmd_t        c;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: empty window
        push_read(0);
        push_sample(0, 5, 1'b1);
        push_read(0);

        // full column count, ten ticks per column
        set_window(1000, 41960, MAX_COLUMNS);
        push_sample(1000, 32'h7FFF_FFFF, 1'b1);
        push_sample(1009, 32'h8000_0000, 1'b1);
        push_read(0);
        push_sample(41959, -7, 1'b1);
        push_sample(41960, 3, 1'b1);
        push_sample(999, 3, 1'b1);
        push_sample(1010, 123, 1'b0);
        c = '1;
        pending_cmds.push_back(c);
        push_read(4095);
        push_read(1);
        pending_cmds.push_back(noise_item(ACT_CLEAR));
        push_read(0);
        push_read(4095);

        // count above the store saturates
        set_window(0, 32'hFFFF_FFFF, 8191);
        push_sample(32'hFFFF_FFFE, 1, 1'b1);
        push_sample(0, 0, 1'b1);
        push_read(4095);

        // read above the count keeps old contents
        set_window(0, 32'hFFFF_FFFF, 16);
        push_read(4095);

        set_window(0, 1000, 0);
        push_sample(5, 9, 1'b1);
        push_read(0);

        set_window(500, 100, 16);
        push_sample(300, 9, 1'b1);
        push_read(0);

        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0:
                begin
                    s = 0;
                    e = 32'hFFFF_FFFF;
                    cdata = MAX_COLUMNS;
                end
                1:
                begin
                    s = $urandom_range(0, 32'h7FFF_FFFF);
                    e = s + $urandom_range(1, 40);
                    cdata = 1;
                end
                2:
                begin
                    s = 32'hFFFF_FF00;
                    e = 32'hFFFF_FFFF;
                    cdata = 256;
                end
                default:
                begin
                    case ($urandom_range(0, 5))
                        0: n = $urandom_range(1, 4);
                        1: n = $urandom_range(5, 64);
                        2: n = $urandom_range(65, 1024);
                        3: n = MAX_COLUMNS;
                        4: n = $urandom_range(MAX_COLUMNS + 1, 8191);
                        default: n = $urandom_range(0, 16);
                    endcase
                    s = ($urandom_range(0, 4) == 0) ? 0 : $urandom();
                    case ($urandom_range(0, 7))
                        0: span64 = 0;
                        1, 2: span64 = $urandom_range(1, 2 * n + 2);
                        3, 4, 5: span64 = 64'(n) * $urandom_range(1, 64);
                        default: span64 = $urandom();
                    endcase
                    if (span64 == 0)
                        e = $urandom_range(0, s);
                    else if (64'(s) + span64 > 64'hFFFF_FFFF)
                        e = '1;
                    else
                        e = s + span64[31:0];
                    cdata = n;
                    bits = $urandom();
                    if (bits[0])
                        cdata[31:COUNT_BITS] = bits[31:COUNT_BITS];
                end
            endcase
            set_window(s, e, cdata);

            window_ok = (win_end > win_start);
            span = win_end - win_start;
            n_eff = (col_count > MAX_COLUMNS) ? MAX_COLUMNS : int'(col_count);
            if (window_ok)
                foreach (hot_times[k])
                    hot_times[k] = win_start + $urandom_range(0, span - 1);
            clears_left = 2;

            for (int i = 0; i < 72; i++)
            begin
                if (p % 4 == 1 && i == 40)
                    drain(0);
                pick = $urandom_range(0, 99);
                if (pick < 2 && clears_left > 0)
                begin
                    clears_left--;
                    pending_cmds.push_back(noise_item(ACT_CLEAR));
                end
                else if (pick < 5)
                begin
                    pending_cmds.push_back(noise_item(ACT_UNUSED));
                end
                else if (pick < 62)
                begin
                    pick = $urandom_range(0, 99);
                    if (window_ok && pick < 50)
                        t = hot_times[$urandom_range(0, 5)] + $urandom_range(0, 3);
                    else if (window_ok && pick < 85)
                        t = win_start + $urandom_range(0, span - 1);
                    else if (pick < 92)
                        case ($urandom_range(0, 3))
                            0: t = win_start;
                            1: t = win_start - 1;
                            2: t = win_end;
                            default: t = win_end - 1;
                        endcase
                    else
                        t = $urandom();
                    case ($urandom_range(0, 5))
                        0: v = 32'h7FFF_FFFF;
                        1: v = 32'h8000_0000;
                        2, 3: v = $urandom_range(0, 200) - 100;
                        default: v = $urandom();
                    endcase
                    push_sample(t, v, $urandom_range(0, 9) != 0);
                end
                else
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6 && hot_cols.size() != 0)
                        push_read(hot_cols[$urandom_range(0, hot_cols.size() - 1)]);
                    else if (pick < 8 && n_eff > 0)
                        push_read($urandom_range(0, n_eff - 1));
                    else
                        push_read($urandom_range(0, MAX_COLUMNS - 1));
                end
            end
        end

        drain(64);
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

/* min_max_column_decimator.f */
src/mcd_pkg.sv
src/mcd_ram.sv
src/min_max_column_decimator.sv
tb/tb_top.sv
